// File: hdl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants for the character-LCD cursor writer: request
// codes, controller bytes, register map and controller/datapath handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  // Request codes
  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_SETPOS = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_HOME   = 2'd3;

  // Controller bytes and characters
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Padding limit per newline
  localparam logic [5:0] PAD_CAP = 6'd40;

  // Register map (register index is paddr[2])
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_LINE_STRIDE   = 1'b0;
  localparam logic REG_VISIBLE_WIDTH = 1'b1;

  localparam logic [6:0] LINE_STRIDE_RST   = 7'd40;
  localparam logic [5:0] VISIBLE_WIDTH_RST = 6'd16;

  // Restoring divider: one quotient bit per cycle over the 8-bit cursor
  localparam int unsigned DIV_STEPS_W = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PAD,
    ST_JUMP
  } state_e;

  // Which beat the datapath loads into the output register
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_DIRECT,
    EMIT_SPACE,
    EMIT_JUMP
  } emit_e;

  typedef struct packed {
    emit_e emit;
    logic  div_init;
    logic  div_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_newline;
    logic div_last;
    logic pad_more;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/char_lcd_cursor_writer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_cursor_writer_unit
// Character-LCD cursor writer: turns text requests into controller bytes and
// tracks a shadow cursor address.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------------------
//  request   | in        | in_valid_i / in_stall_o    | req_type, char_code,
//            |           |                            | line_sel, column
//  result    | out       | out_valid_o / out_stall_i  | reg_select, bus_byte,
//            |           |                            | last, cursor_address
//  config    | in        | APB psel/penable/pwrite    | line_stride @0,
//            |           |                            | visible_width @4
//
//  Put (non-newline), set position, clear and home: one beat each.
//  Newline: an accept step, the bit-serial column divider, one space beat
//  per padded column (0 to 40), a step to leave padding and then the
//  set-address beat.
//  A stalled output register holds the sequencer; requests wait until idle.
//  Reset clears the cursor to 0 and loads stride 40 and width 16.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_cursor_writer_unit
  import clcd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // request channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [7:0]            char_code_i,
  input  wire logic                  line_sel_i,
  input  wire logic [5:0]            column_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       reg_select_o,
  output logic      [7:0]            bus_byte_o,
  output logic                       last_o,
  output logic      [7:0]            cursor_address_o
);

  cmd_t    cmd;
  status_t status;

  clcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clcd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .req_type_i       (req_type_i),
    .char_code_i      (char_code_i),
    .line_sel_i       (line_sel_i),
    .column_i         (column_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reg_select_o     (reg_select_o),
    .bus_byte_o       (bus_byte_o),
    .last_o           (last_o),
    .cursor_address_o (cursor_address_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

  // Never load a beat over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit != EMIT_NONE) |-> (!out_valid_o || !out_stall_i))
    else $error("beat loaded over a stalled beat");

  // Space beats only while padding is still owed
  a_space_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit == EMIT_SPACE) |-> status.pad_more)
    else $error("space beat past the padding limit");

  // A single-beat request shows its final beat in the next cycle
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !status.is_newline) |=> (out_valid_o && last_o))
    else $error("single-beat request did not produce a final beat");

  // Divider is busy only between an accepted newline and the padding
  a_div_after_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_init |=> (cmd.div_step && !out_valid_o || cmd.div_step && in_stall_o))
    else $error("divider did not start after a newline");

endmodule

`default_nettype wire

// File: hdl/clcd_ctrl.sv
// ----------------------------------------------------------------------------
// clcd_ctrl
// Request sequencer: takes requests, runs the column divide for a newline,
// paces the space padding and issues the final set-address command.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_ctrl
  import clcd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // Take a request only when idle and the output register can load a beat
  assign in_stall_o = !((state_q == ST_IDLE) && status_i.out_free);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.out_free && status_i.is_newline) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_PAD;
      end
      ST_PAD: begin
        if (!status_i.pad_more) state_d = ST_JUMP;
      end
      ST_JUMP: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o = '{emit: EMIT_NONE, div_init: 1'b0, div_step: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.out_free) begin
          if (status_i.is_newline) cmd_o.div_init = 1'b1;
          else                     cmd_o.emit     = EMIT_DIRECT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_PAD: begin
        if (status_i.pad_more && status_i.out_free) cmd_o.emit = EMIT_SPACE;
      end
      ST_JUMP: begin
        if (status_i.out_free) cmd_o.emit = EMIT_JUMP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/clcd_dp.sv
// ----------------------------------------------------------------------------
// clcd_dp
// Datapath: configuration registers, shadow cursor, restoring divider that
// doubles as the column counter, pad counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_dp
  import clcd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // request fields
  input  wire logic [1:0]            req_type_i,
  input  wire logic [7:0]            char_code_i,
  input  wire logic                  line_sel_i,
  input  wire logic [5:0]            column_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       reg_select_o,
  output logic      [7:0]            bus_byte_o,
  output logic                       last_o,
  output logic      [7:0]            cursor_address_o,
  // controller link
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o
);

  logic [6:0] stride_q;
  logic [5:0] width_q;
  logic [7:0] cursor_q, cursor_d;
  logic [7:0] col_q, col_d;            // remainder during divide, column after
  logic [7:0] dividend_q, dividend_d;
  logic [DIV_STEPS_W-1:0] div_cnt_q, div_cnt_d;
  logic [5:0] pad_cnt_q, pad_cnt_d;
  logic       out_valid_q;
  logic       rs_q, rs_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;

  logic [6:0] stride_eff;
  logic [5:0] vis_eff;
  logic [7:0] rem_sh;
  logic [7:0] setpos_addr;
  logic [6:0] jump_addr;
  logic [7:0] col_inc;
  logic       cfg_write;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= LINE_STRIDE_RST;
      width_q  <= VISIBLE_WIDTH_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_LINE_STRIDE) stride_q <= pwdata[6:0];
      else                             width_q  <= pwdata[5:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_VISIBLE_WIDTH) prdata = {{(APB_DATA_W-6){1'b0}}, width_q};
    else                               prdata = {{(APB_DATA_W-7){1'b0}}, stride_q};
  end

  // Effective stride and padding width
  assign stride_eff = (stride_q == 7'd0) ? 7'd1 : stride_q;
  assign vis_eff    = (width_q > PAD_CAP) ? PAD_CAP : width_q;

  // Divider step, set-position address, newline jump target, column advance
  assign rem_sh      = {col_q[6:0], dividend_q[7]};
  assign setpos_addr = (line_sel_i ? {1'b0, stride_eff} : 8'd0) + {2'b00, column_i};
  assign jump_addr   = (cursor_q < {1'b0, stride_eff}) ? stride_eff : 7'd0;
  assign col_inc     = col_q + 8'd1;

  // Status to the controller
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.is_newline = (req_type_i == REQ_PUT) && (char_code_i == CHAR_NEWLINE);
  assign status_o.div_last   = (div_cnt_q == {DIV_STEPS_W{1'b1}});
  assign status_o.pad_more   = (col_q < {2'b00, vis_eff}) && (pad_cnt_q < PAD_CAP);

  // Cursor, divider, counters and next output beat
  always_comb begin
    cursor_d   = cursor_q;
    col_d      = col_q;
    dividend_d = dividend_q;
    div_cnt_d  = div_cnt_q;
    pad_cnt_d  = pad_cnt_q;
    rs_d       = rs_q;
    byte_d     = byte_q;
    last_d     = last_q;

    if (cmd_i.div_init) begin
      col_d      = 8'd0;
      dividend_d = cursor_q;
      div_cnt_d  = '0;
      pad_cnt_d  = 6'd0;
    end

    if (cmd_i.div_step) begin
      col_d      = (rem_sh >= {1'b0, stride_eff}) ? rem_sh - {1'b0, stride_eff} : rem_sh;
      dividend_d = {dividend_q[6:0], 1'b0};
      div_cnt_d  = div_cnt_q + 1'b1;
    end

    case (cmd_i.emit)
      EMIT_DIRECT: begin
        last_d = 1'b1;
        case (req_type_i)
          REQ_PUT: begin
            rs_d     = 1'b1;
            byte_d   = char_code_i;
            cursor_d = cursor_q + 8'd1;
          end
          REQ_SETPOS: begin
            rs_d     = 1'b0;
            byte_d   = CMD_SET_ADDR | {1'b0, setpos_addr[6:0]};
            cursor_d = {1'b0, setpos_addr[6:0]};
          end
          REQ_CLEAR: begin
            rs_d     = 1'b0;
            byte_d   = CMD_CLEAR;
            cursor_d = 8'd0;
          end
          default: begin
            rs_d     = 1'b0;
            byte_d   = CMD_HOME;
            cursor_d = 8'd0;
          end
        endcase
      end
      EMIT_SPACE: begin
        rs_d      = 1'b1;
        byte_d    = CHAR_SPACE;
        last_d    = 1'b0;
        cursor_d  = cursor_q + 8'd1;
        pad_cnt_d = pad_cnt_q + 6'd1;
        // column restarts on a line boundary or when the cursor wraps
        if (cursor_q == 8'hFF || col_inc == {1'b0, stride_eff}) col_d = 8'd0;
        else                                                    col_d = col_inc;
      end
      EMIT_JUMP: begin
        rs_d     = 1'b0;
        byte_d   = CMD_SET_ADDR | {1'b0, jump_addr};
        last_d   = 1'b1;
        cursor_d = {1'b0, jump_addr};
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= 8'd0;
      div_cnt_q   <= '0;
      pad_cnt_q   <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q  <= cursor_d;
      div_cnt_q <= div_cnt_d;
      pad_cnt_q <= pad_cnt_d;
      if (cmd_i.emit != EMIT_NONE) out_valid_q <= 1'b1;
      else if (!out_stall_i)       out_valid_q <= 1'b0;
    end
  end

  // Payload and divider registers
  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    dividend_q <= dividend_d;
    rs_q       <= rs_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign reg_select_o     = rs_q;
  assign bus_byte_o       = byte_q;
  assign last_o           = last_q;
  assign cursor_address_o = cursor_q;

endmodule

`default_nettype wire

// File: tb/sv/char_lcd_cursor_writer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_cursor_writer_checker
// Watches the request, result and configuration ports of the cursor writer.
// It mirrors the register writes, predicts the controller bytes and the
// shadow cursor for every accepted request, and compares each result beat
// field by field with the oldest predicted byte.
// ----------------------------------------------------------------------------
module char_lcd_cursor_writer_checker
  import clcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  // request channel
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            req_type_i,
  input  logic [7:0]            char_code_i,
  input  logic                  line_sel_i,
  input  logic [5:0]            column_i,
  // result channel
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  reg_select_i,
  input  logic [7:0]            bus_byte_i,
  input  logic                  last_i,
  input  logic [7:0]            cursor_address_i,
  // status for the stimulus side
  output int                    fail_count_o,
  output int                    bytes_due_o
);

  localparam logic [7:0] ADDR_MASK = 8'h7F;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last;
    logic [7:0] cursor_address;
  } lcd_beat_t;

  logic [6:0] line_stride_q   = LINE_STRIDE_RST;
  logic [5:0] visible_width_q = VISIBLE_WIDTH_RST;
  logic [7:0] cursor_q        = 8'd0;
  lcd_beat_t  bytes_due_q[$];
  int         fails           = 0;

  // Queue one controller byte, tagged with the cursor as it stands now
  function automatic void add_beat(logic rs, logic [7:0] value, logic lst);
    lcd_beat_t b;
    b.reg_select     = rs;
    b.bus_byte       = value;
    b.last           = lst;
    b.cursor_address = cursor_q;
    bytes_due_q.push_back(b);
  endfunction

  // Work out the bytes one request produces and advance the shadow cursor
  function automatic void predict_request(logic [1:0] req, logic [7:0] ch, logic line,
                                          logic [5:0] col);
    int         step;
    int         span;
    int         spaces;
    int         sum;
    logic [7:0] target;
    step = (line_stride_q == 7'd0) ? 1 : int'(line_stride_q);
    span = (visible_width_q > PAD_CAP) ? int'(PAD_CAP) : int'(visible_width_q);
    case (req)
      REQ_PUT: begin
        if (ch != CHAR_NEWLINE) begin
          cursor_q = cursor_q + 8'd1;
          add_beat(1'b1, ch, 1'b1);
        end else begin
          // pad the visible rest of the line, never more than the cap
          spaces = 0;
          while (spaces < int'(PAD_CAP) && (int'(cursor_q) % step) < span) begin
            cursor_q = cursor_q + 8'd1;
            add_beat(1'b1, CHAR_SPACE, 1'b0);
            spaces++;
          end
          // line zero jumps to the stride, any other line back to zero
          sum      = (int'(cursor_q) / step == 0) ? step : 0;
          target   = sum[7:0];
          cursor_q = target;
          add_beat(1'b0, CMD_SET_ADDR | (target & ADDR_MASK), 1'b1);
        end
      end
      REQ_SETPOS: begin
        sum      = (line ? step : 0) + int'(col);
        target   = sum[7:0];
        cursor_q = target & ADDR_MASK;
        add_beat(1'b0, CMD_SET_ADDR | cursor_q, 1'b1);
      end
      REQ_CLEAR: begin
        cursor_q = 8'd0;
        add_beat(1'b0, CMD_CLEAR, 1'b1);
      end
      REQ_HOME: begin
        cursor_q = 8'd0;
        add_beat(1'b0, CMD_HOME, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lcd_beat_t want;
    if (!rst_ni) begin
      line_stride_q   = LINE_STRIDE_RST;
      visible_width_q = VISIBLE_WIDTH_RST;
      cursor_q        = 8'd0;
      bytes_due_q.delete();
    end else begin
      // compare a result beat against the oldest predicted byte
      if (out_valid_i && !out_stall_i) begin
        if (bytes_due_q.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual bus_byte 0x%0h",
                   $time, bus_byte_i);
          fails++;
        end else begin
          want = bytes_due_q.pop_front();
          check_field("reg_select", {7'b0, want.reg_select}, {7'b0, reg_select_i});
          check_field("bus_byte", want.bus_byte, bus_byte_i);
          check_field("last", {7'b0, want.last}, {7'b0, last_i});
          check_field("cursor_address", want.cursor_address, cursor_address_i);
        end
      end
      // predict the bytes of an accepted request
      if (in_valid_i && !in_stall_i) begin
        predict_request(req_type_i, char_code_i, line_sel_i, column_i);
      end
      // mirror register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LINE_STRIDE) begin
          line_stride_q = pwdata[6:0];
        end else begin
          visible_width_q = pwdata[5:0];
        end
      end
    end
    fail_count_o = fails;
    bytes_due_o  = bytes_due_q.size();
  end

endmodule

// File: tb/sv/char_lcd_cursor_writer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_cursor_writer_unit_tb
// Drives text requests and register writes into the cursor writer: a short
// directed run over the corner cases, then random text under several line
// strides and visible widths, with random gaps and stalls on both channels,
// a long output hold-off and quiet stretches. The checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module char_lcd_cursor_writer_unit_tb;
  import clcd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 60;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [APB_ADDR_W-1:0] paddr      = '0;
  logic [APB_DATA_W-1:0] pwdata     = '0;
  wire  [APB_DATA_W-1:0] prdata;
  wire                   pready;
  logic                  in_valid   = 1'b0;
  wire                   in_stall;
  logic [1:0]            req_type   = REQ_PUT;
  logic [7:0]            char_code  = 8'd0;
  logic                  line_sel   = 1'b0;
  logic [5:0]            column     = 6'd0;
  wire                   out_valid;
  logic                  out_stall  = 1'b0;
  wire                   reg_select;
  wire  [7:0]            bus_byte;
  wire                   last_beat;
  wire  [7:0]            cursor_address;
  int                    fail_count;
  int                    bytes_due;
  int                    cycle_count = 0;
  bit                    no_idle     = 1'b0;
  bit                    hold_req    = 1'b0;

  char_lcd_cursor_writer_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (req_type),
    .char_code_i      (char_code),
    .line_sel_i       (line_sel),
    .column_i         (column),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .reg_select_o     (reg_select),
    .bus_byte_o       (bus_byte),
    .last_o           (last_beat),
    .cursor_address_o (cursor_address)
  );

  char_lcd_cursor_writer_checker byte_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .req_type_i       (req_type),
    .char_code_i      (char_code),
    .line_sel_i       (line_sel),
    .column_i         (column),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .reg_select_i     (reg_select),
    .bus_byte_i       (bus_byte),
    .last_i           (last_beat),
    .cursor_address_i (cursor_address),
    .fail_count_o     (fail_count),
    .bytes_due_o      (bytes_due)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 13));
  endfunction

  // Setup phase, then access phase until pready, then an idle phase
  task automatic write_reg(logic idx, logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(APB_DATA_W-7){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one request beat after a random gap and hold it until accepted
  task automatic send_request(logic [1:0] req, logic [7:0] ch, logic line, logic [5:0] col);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    char_code <= ch;
    line_sel  <= line;
    column    <= col;
    do @(posedge clk_i); while (in_stall !== 1'b0);
  endtask

  // Stop offering and wait until every predicted byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (bytes_due != 0);
  endtask

  task automatic set_config(logic [6:0] stride, logic [5:0] width);
    drain();
    write_reg(REG_LINE_STRIDE, stride);
    write_reg(REG_VISIBLE_WIDTH, {1'b0, width});
  endtask

  // Random request; text mostly, with newlines, positioning, clear and home
  task automatic send_random(bit chars_only);
    int          pick;
    logic [31:0] r;
    logic [1:0]  req;
    logic [7:0]  ch;
    pick = $urandom_range(0, 99);
    r    = $urandom();
    ch   = r[15:8];
    if (chars_only || pick < 55) begin
      req = REQ_PUT;
      if (chars_only && ch == CHAR_NEWLINE) ch = CHAR_SPACE;
    end else if (pick < 70) begin
      req = REQ_PUT;
      ch  = CHAR_NEWLINE;
    end else if (pick < 85) begin
      req = REQ_SETPOS;
    end else if (pick < 93) begin
      req = REQ_CLEAR;
    end else begin
      req = REQ_HOME;
    end
    send_request(req, ch, r[0], r[6:1]);
  endtask

  // Result side: random stall per beat, with one long hold-off on request
  initial begin
    int hold;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold     = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        hold = draw_wait();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid !== 1'b1);
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: stride 40, width 16
    send_request(REQ_PUT, 8'h41, 1'b0, 6'd0);
    send_request(REQ_PUT, 8'h00, 1'b1, 6'd63);
    send_request(REQ_PUT, 8'hFF, 1'b0, 6'd0);
    send_request(REQ_PUT, 8'h0B, 1'b0, 6'd0);
    send_request(REQ_PUT, CHAR_NEWLINE, 1'b0, 6'd0);
    send_request(REQ_PUT, CHAR_NEWLINE, 1'b0, 6'd0);
    // past the visible width and on a line beyond the second
    send_request(REQ_SETPOS, 8'h00, 1'b1, 6'd63);
    send_request(REQ_PUT, CHAR_NEWLINE, 1'b1, 6'd63);
    // ignored fields carry extremes
    send_request(REQ_SETPOS, 8'hFF, 1'b0, 6'd0);
    send_request(REQ_CLEAR, CHAR_NEWLINE, 1'b1, 6'd63);
    send_request(REQ_HOME, 8'hFF, 1'b1, 6'd63);

    // zero stride acts as one; wide width hits the padding cap
    set_config(7'd0, 6'd63);
    send_request(REQ_PUT, CHAR_NEWLINE, 1'b0, 6'd0);
    send_request(REQ_SETPOS, 8'h00, 1'b1, 6'd5);

    // widest stride, no padding; set position wraps past 7 address bits
    set_config(7'd127, 6'd0);
    send_request(REQ_PUT, CHAR_NEWLINE, 1'b0, 6'd0);
    send_request(REQ_SETPOS, 8'h00, 1'b1, 6'd63);
    send_request(REQ_PUT, 8'h7F, 1'b0, 6'd0);

    set_config(7'd64, 6'd40);
    send_request(REQ_SETPOS, 8'h00, 1'b1, 6'd63);
    send_request(REQ_PUT, 8'h20, 1'b0, 6'd0);
    send_request(REQ_PUT, CHAR_NEWLINE, 1'b0, 6'd0);
    send_request(REQ_PUT, 8'h80, 1'b0, 6'd0);

    set_config(7'd1, 6'd1);
    send_request(REQ_PUT, CHAR_NEWLINE, 1'b0, 6'd0);
    send_request(REQ_HOME, 8'h00, 1'b0, 6'd0);

    // random text at reset settings
    set_config(LINE_STRIDE_RST, VISIBLE_WIDTH_RST);
    repeat (80) send_random(1'b0);

    // hold the result side off while requests keep coming back to back
    set_config(7'd20, 6'd20);
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (25) send_random(1'b0);
    no_idle = 1'b0;
    repeat (55) send_random(1'b0);

    // long run of characters from the top address wraps the cursor
    set_config(7'd127, 6'd40);
    send_request(REQ_SETPOS, 8'h00, 1'b1, 6'd0);
    repeat (130) send_random(1'b1);

    // no idling on either side
    set_config(7'd64, 6'd40);
    no_idle = 1'b1;
    repeat (60) send_random(1'b0);
    no_idle = 1'b0;

    set_config(7'd0, 6'd0);
    repeat (50) send_random(1'b0);

    set_config(7'($urandom_range(1, 64)), 6'($urandom_range(1, 40)));
    repeat (50) send_random(1'b0);

    // let the last beats out, then give the verdict
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/clcd_pkg.sv
hdl/clcd_ctrl.sv
hdl/clcd_dp.sv
hdl/char_lcd_cursor_writer_unit.sv
tb/sv/char_lcd_cursor_writer_checker.sv
tb/sv/char_lcd_cursor_writer_unit_tb.sv
